>>> hw/rtl/swpc_pkg.sv
// Shared types, widths and helpers for the sliding-window peak request counter.
package swpc_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int COUNT_W = $clog2(RING_DEPTH + 1);

  localparam int STAMP_W = 32;
  localparam int WINDOW_W = 31;
  localparam int COUNT_OUT_W = 11;
  localparam int ERROR_W = 32;

  localparam int IN_USER_W = 2;
  localparam int OUT_FIELDS_W = 2 * COUNT_OUT_W + 2 * STAMP_W + ERROR_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_DONE
  } seq_state_t;

  // Ring pointer increment with wrap at the ring depth.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] result;
    if (ptr == PTR_W'(RING_DEPTH - 1)) begin
      result = '0;
    end else begin
      result = ptr + PTR_W'(1);
    end
    return result;
  endfunction

endpackage

>>> hw/rtl/sliding_window_peak_request_count.sv
// Top level of the sliding-window peak request counter.
// Each request on the slave stream is one log record: tdata carries the
// timestamp in seconds, tuser carries the time-valid flag and the server-error
// flag. A record with a valid time is pushed into a ring of timestamps; the
// oldest entries are then dropped while they lie more than window_seconds
// before the new time. The ring occupancy is the window count, and the largest
// count seen so far is kept together with the start and end of that window.
// Every record yields exactly one request on the master stream.
// The window length is written through the cfg channel, which is always
// ready; it should only change while no record is in flight.
// Sequence: a record with a valid time is pushed into the ring and then
// scanned, one ring entry per cycle through the single read port of the
// timestamp memory; a record without a time, or one that finds the ring empty,
// skips the scan. The result is then loaded into the output register, and only
// after that load is the next record accepted. A stalled receiver holds the
// result there, and the block waits in its final step until the register frees up.
// Synchronous reset clears the pointers, counts, peak and error total and
// restores a window length of 60 seconds; the ring contents need no clearing.
module sliding_window_peak_request_count (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel: window_seconds.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swpc_pkg::WINDOW_W-1:0]       cfg_data,
  // Record input.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swpc_pkg::STAMP_W-1:0]        s_axis_tdata,  // stamp_seconds
  input  logic [swpc_pkg::IN_USER_W-1:0]      s_axis_tuser,  // time_valid, server_error
  // Result output.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // window_count, peak_count, peak_start, peak_end, error_total, zero padding
  output logic [swpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser   // overflowed
);

  import swpc_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  logic [WINDOW_W-1:0] window_seconds;
  logic [PTR_W-1:0]    oldest_ptr;
  logic [PTR_W-1:0]    newest_ptr;
  logic [COUNT_W-1:0]  occupancy;
  logic [COUNT_W-1:0]  best_count;
  logic [STAMP_W-1:0]  best_start;
  logic [STAMP_W-1:0]  best_end;
  logic [ERROR_W-1:0]  error_counter;

  // Record held while it is processed.
  logic                rec_valid;
  logic [STAMP_W-1:0]  rec_stamp;
  logic                rec_err;
  logic                over_flag;
  logic [STAMP_W-1:0]  start_val;

  logic                in_accept;
  logic                slot_free;
  logic                out_load;
  logic                ring_full;
  logic [PTR_W-1:0]    oldest_adv;
  logic [PTR_W-1:0]    push_oldest;
  logic [COUNT_W-1:0]  push_count;
  logic [PTR_W-1:0]    rd_addr;
  logic [STAMP_W-1:0]  rd_data;
  logic                wr_en;
  logic                too_old;
  logic                scan_pop;
  logic                peak_update;
  logic [COUNT_W-1:0]  best_count_next;
  logic [STAMP_W-1:0]  best_start_next;
  logic [STAMP_W-1:0]  best_end_next;
  logic [ERROR_W-1:0]  error_counter_next;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  // A full ring drops its oldest entry before the new stamp goes in.
  assign ring_full = (occupancy == COUNT_W'(RING_DEPTH));
  assign oldest_adv = ring_next(oldest_ptr);
  assign push_oldest = ring_full ? oldest_adv : oldest_ptr;
  assign push_count = ring_full ? occupancy : occupancy + COUNT_W'(1);

  // The push step reads the entry that will be oldest after the push; each
  // scan step reads the entry behind the current oldest, so that a pop finds
  // its next candidate on the following cycle. Writes only happen in the push
  // step, so a read never races a write to the same live entry.
  assign rd_addr = (state == S_PUSH) ? push_oldest : oldest_adv;
  assign wr_en = (state == S_PUSH) && rec_valid;

  swpc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (RING_DEPTH)
  ) u_stamp_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (newest_ptr),
    .wr_data (rec_stamp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The newest entry itself is never dropped, and a stamp that went backwards
  // never drops anything.
  assign too_old = (rec_stamp > rd_data) &&
                   ((rec_stamp - rd_data) > {1'b0, window_seconds});
  assign scan_pop = (state == S_SCAN) && (occupancy > COUNT_W'(1)) && too_old;

  always_comb begin
    state_next = state;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (rec_valid && (push_count > COUNT_W'(1))) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (!scan_pop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Peak and error total as they stand after the current record.
  assign peak_update = rec_valid && (occupancy > best_count);
  assign best_count_next = peak_update ? occupancy : best_count;
  assign best_start_next = peak_update ? start_val : best_start;
  assign best_end_next = peak_update ? rec_stamp : best_end;
  assign error_counter_next = (rec_err && (error_counter != '1)) ?
                              error_counter + ERROR_W'(1) : error_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_RESET;
      oldest_ptr <= '0;
      newest_ptr <= '0;
      occupancy <= '0;
      best_count <= '0;
      best_start <= '0;
      best_end <= '0;
      error_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_seconds <= cfg_data;
      end
      if (wr_en) begin
        oldest_ptr <= push_oldest;
        newest_ptr <= ring_next(newest_ptr);
        occupancy <= push_count;
      end
      if (scan_pop) begin
        oldest_ptr <= oldest_adv;
        occupancy <= occupancy - COUNT_W'(1);
      end
      if (out_load) begin
        best_count <= best_count_next;
        best_start <= best_start_next;
        best_end <= best_end_next;
        error_counter <= error_counter_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rec_valid <= s_axis_tuser[0];
      rec_stamp <= s_axis_tdata;
      rec_err <= s_axis_tuser[1];
    end
    if (state == S_PUSH) begin
      over_flag <= rec_valid && ring_full;
      // With a single entry left, the window starts at the new stamp.
      start_val <= rec_stamp;
    end
    if ((state == S_SCAN) && !scan_pop && (occupancy > COUNT_W'(1))) begin
      start_val <= rd_data;
    end
    if (out_load) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}},
                       error_counter_next,
                       best_end_next,
                       best_start_next,
                       COUNT_OUT_W'(best_count_next),
                       COUNT_OUT_W'(occupancy)};
      m_axis_tuser <= over_flag;
    end
  end

`ifndef SYNTHESIS
  a_occupancy_bound : assert property (
    @(posedge clk) disable iff (rst)
    occupancy <= COUNT_W'(RING_DEPTH)
  ) else $error("ring occupancy exceeds the ring depth");

  a_peak_not_below_window : assert property (
    @(posedge clk) disable iff (rst)
    out_load |=> (best_count >= occupancy)
  ) else $error("peak count fell below the window count");

  a_error_total_on_load : assert property (
    @(posedge clk) disable iff (rst)
    !$stable(error_counter) |-> $past(out_load)
  ) else $error("error total changed outside of a result load");

  a_scan_has_entries : assert property (
    @(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (occupancy != '0)
  ) else $error("window scan running on an empty ring");
`endif

endmodule

>>> hw/rtl/swpc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module swpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> dv/tb.sv
// Testbench for the sliding-window peak request counter: random and directed records, self-checked.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swpc_pkg::*;

  // Result fields in tdata order, window_count in the lowest bits.
  typedef struct packed {
    logic [ERROR_W-1:0]     error_total;
    logic [STAMP_W-1:0]     peak_end;
    logic [STAMP_W-1:0]     peak_start;
    logic [COUNT_OUT_W-1:0] peak_count;
    logic [COUNT_OUT_W-1:0] window_count;
  } window_fields_t;

  typedef struct packed {
    logic           overflowed;
    window_fields_t fields;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [WINDOW_W-1:0]     cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [STAMP_W-1:0]      s_axis_tdata = '0;
  logic [IN_USER_W-1:0]    s_axis_tuser = '0;  // time_valid, server_error
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;       // result fields, zero padding on top
  logic                    m_axis_tuser;       // overflowed

  sliding_window_peak_request_count uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the window state, updated once per accepted record.
  logic [STAMP_W-1:0]  stamp_mem [RING_DEPTH];
  int unsigned         oldest_slot = 0;
  int unsigned         newest_slot = 0;
  int unsigned         held = 0;
  int unsigned         best_held = 0;
  logic [STAMP_W-1:0]  best_first = '0;
  logic [STAMP_W-1:0]  best_last = '0;
  logic [ERROR_W-1:0]  server_errors = '0;
  logic [WINDOW_W-1:0] window_setting = WINDOW_RESET;

  window_result_t expected_windows[$];
  int unsigned    mismatch_count = 0;

  // Idling controls: sender gap chance in percent, and a master switch that
  // also governs receiver stalls.
  bit          idle_enable = 1'b1;
  int unsigned gap_pct = 25;
  int unsigned stall_left = 0;
  logic [STAMP_W-1:0] cursor = '0;

  // Computes the result of one record and advances the window state.
  function automatic window_result_t window_predict(input logic tv, input logic [STAMP_W-1:0] stamp,
                                                    input logic err);
    window_result_t     r;
    logic [STAMP_W-1:0] first;
    bit                 scanning;
    r = '0;
    if (tv) begin
      // A full ring loses its oldest entry to make room for the new one.
      if (held >= RING_DEPTH) begin
        oldest_slot = (oldest_slot + 1) % RING_DEPTH;
        held--;
        r.overflowed = 1'b1;
      end
      stamp_mem[newest_slot] = stamp;
      newest_slot = (newest_slot + 1) % RING_DEPTH;
      held++;
      // Entries older than the window drop out; a stamp that went backwards
      // never pops anything, and the newest entry always stays.
      scanning = 1'b1;
      while (scanning && held > 1) begin
        first = stamp_mem[oldest_slot];
        if (stamp > first && (stamp - first) > {1'b0, window_setting}) begin
          oldest_slot = (oldest_slot + 1) % RING_DEPTH;
          held--;
        end else begin
          scanning = 1'b0;
        end
      end
      // Ties leave the recorded peak alone.
      if (held > best_held) begin
        best_held  = held;
        best_first = stamp_mem[oldest_slot];
        best_last  = stamp;
      end
    end
    if (err && server_errors != '1) server_errors++;
    r.fields.window_count = COUNT_OUT_W'(held);
    r.fields.peak_count   = COUNT_OUT_W'(best_held);
    r.fields.peak_start   = best_first;
    r.fields.peak_end     = best_last;
    r.fields.error_total  = server_errors;
    return r;
  endfunction

  // Offers one record, with an optional random gap first, and books its
  // expected result once the block takes it.
  task automatic send_record(input logic tv, input logic [STAMP_W-1:0] stamp, input logic err);
    int unsigned gap;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= {err, tv};
    do @(posedge clk); while (!s_axis_tready);
    expected_windows.push_back(window_predict(tv, stamp, err));
  endtask

  // Stops offering records and waits until every expected result is back.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Window length may only change while nothing is in flight.
  task automatic write_window(input logic [WINDOW_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    window_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls come in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Every result request is compared with the oldest expectation.
  always @(posedge clk) begin
    window_result_t want;
    window_fields_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_FIELDS_W-1:0];
      if (expected_windows.size() == 0) begin
        $display("%0t ns: result request with none expected, actual %0h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_windows.pop_front();
        check_field("window_count", want.fields.window_count, got.window_count);
        check_field("peak_count", want.fields.peak_count, got.peak_count);
        check_field("peak_start", want.fields.peak_start, got.peak_start);
        check_field("peak_end", want.fields.peak_end, got.peak_end);
        check_field("error_total", want.fields.error_total, got.error_total);
        check_field("overflowed", want.overflowed, m_axis_tuser);
      end
    end
  end

  // With the reset window of 60 s: records without time, equal stamps, the
  // exact window edge, ties, stamps going backwards and the stamp extremes.
  task automatic test_reset_window();
    send_record(1'b0, 32'd0, 1'b1);
    send_record(1'b1, 32'd100, 1'b0);
    send_record(1'b1, 32'd100, 1'b1);
    send_record(1'b1, 32'd160, 1'b0);
    send_record(1'b1, 32'd161, 1'b0);
    send_record(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_record(1'b1, 32'd50, 1'b0);
    send_record(1'b1, 32'hFFFF_FFFF, 1'b1);
    send_record(1'b1, 32'd0, 1'b0);
  endtask

  // Zero window, the widest window and the narrowest nonzero one.
  task automatic test_window_extremes();
    write_window('0);
    send_record(1'b1, 32'd500, 1'b0);
    send_record(1'b1, 32'd500, 1'b1);
    send_record(1'b1, 32'd501, 1'b0);
    send_record(1'b1, 32'd501, 1'b0);
    write_window('1);
    send_record(1'b1, 32'd501 + 32'h7FFF_FFFF, 1'b0);
    send_record(1'b1, 32'd502 + 32'h7FFF_FFFF, 1'b1);
    write_window(WINDOW_W'(1));
    send_record(1'b1, 32'd503 + 32'h7FFF_FFFF, 1'b0);
    send_record(1'b1, 32'd505 + 32'h7FFF_FFFF, 1'b0);
    send_record(1'b0, 32'h5555_AAAA, 1'b1);
  endtask

  // Mostly ordered stamps with random steps sized to the window, plus jumps,
  // backward stamps, records without time and full pauses.
  task automatic test_random_traffic();
    logic [WINDOW_W-1:0] win;
    int unsigned         step_max;
    int unsigned         pick;
    logic                err;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: win = WINDOW_W'(1);
        1: win = '1;
        2: win = WINDOW_W'($urandom_range(2, 300));
        3: win = WINDOW_W'($urandom);
        4: win = WINDOW_W'($urandom_range(0, 20));
        default: win = WINDOW_W'(60);
      endcase
      write_window(win);
      idle_enable = ($urandom_range(0, 3) != 0);
      gap_pct = $urandom_range(0, 40);
      step_max = (win == 0) ? 1 : 32'(win) / $urandom_range(2, 40);
      if (step_max == 0) step_max = 1;
      cursor = $urandom;
      for (int n = 0; n < 15; n++) begin
        pick = $urandom_range(0, 99);
        err = ($urandom_range(0, 3) == 0);
        if (pick < 78) begin
          cursor = cursor + $urandom_range(0, step_max);
          send_record(1'b1, cursor, err);
        end else if (pick < 84) begin
          cursor = cursor + $urandom;
          send_record(1'b1, cursor, err);
        end else if (pick < 90) begin
          send_record(1'b1, cursor - $urandom_range(0, step_max), err);
        end else if (pick < 98) begin
          send_record(1'b0, $urandom, err);
        end else begin
          // Let the block run dry before the next record.
          drain_results();
          send_record(1'b1, cursor, err);
        end
      end
    end
  endtask

  // Fills the ring past its depth inside one wide window, then jumps far
  // ahead so that the oldest entries of the ring are scanned out in one record.
  task automatic test_ring_overflow();
    logic [STAMP_W-1:0] base;
    write_window('1);
    base = cursor;
    for (int n = 0; n < RING_DEPTH + 4; n++) begin
      send_record(1'b1, base + STAMP_W'(n / 16), ($urandom_range(0, 2) == 0));
    end
    cursor = base + 32'h8000_0010;
    send_record(1'b1, cursor, 1'b0);
    send_record(1'b0, cursor, 1'b1);
    send_record(1'b1, cursor, 1'b0);
    send_record(1'b1, cursor + 32'd1, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_extremes();
    test_random_traffic();
    // The closing stretch runs with no idling on either side.
    idle_enable = 1'b0;
    test_ring_overflow();

    drain_results();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
